// File: rtl/core/fcea_pkg.sv
// ----------------------------------------------------------------------------
// fcea_pkg
// Shared types and constants of the flow counter extension and aging block.
// ----------------------------------------------------------------------------
`default_nettype none

package fcea_pkg;

  // Table depth; indexes are reduced to the low address bits.
  localparam int FLOW_ENTRIES = 4096;
  localparam int ADDR_W       = $clog2(FLOW_ENTRIES);

  localparam int INDEX_W      = 12;
  localparam int KBYTES_W     = 48;
  localparam int KPKTS_W      = 40;
  localparam int TOTAL_W      = 64;
  localparam int TIME_W       = 64;
  localparam int INTERVAL_W   = 40;
  localparam int DBYTES_W     = KBYTES_W + 1;
  localparam int DPKTS_W      = KPKTS_W + 1;

  localparam logic [INTERVAL_W-1:0] AGE_INTERVAL_RESET = INTERVAL_W'(180000000);

  // Item kinds.
  localparam logic ACT_CREATE = 1'b0;
  localparam logic ACT_SCAN   = 1'b1;

  // One table entry.
  typedef struct packed {
    logic [TOTAL_W-1:0] byte_total;
    logic [TOTAL_W-1:0] packet_total;
    logic [TIME_W-1:0]  stamp;
    logic               mark;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FLOW,
    ST_RD_REV,
    ST_CAP_REV,
    ST_CALC_A,
    ST_CALC_B,
    ST_CALC_C,
    ST_COMMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic rd_rev;
    logic cap_flow;
    logic cap_rev;
    logic calc_a;
    logic calc_b;
    logic calc_c;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_scan;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/fcea_ctrl.sv
// ----------------------------------------------------------------------------
// fcea_ctrl
// Sequencer: reads flow and reverse entries, steps the datapath, commits.
// ----------------------------------------------------------------------------
`default_nettype none

module fcea_ctrl
  import fcea_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RD_FLOW;
      end
      ST_RD_FLOW: begin
        // create items need no table data
        state_next = sts.is_scan ? ST_RD_REV : ST_COMMIT;
      end
      ST_RD_REV:  state_next = ST_CAP_REV;
      ST_CAP_REV: state_next = ST_CALC_A;
      ST_CALC_A:  state_next = ST_CALC_B;
      ST_CALC_B:  state_next = ST_CALC_C;
      ST_CALC_C:  state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_RD_FLOW: begin
        cmd.rd_en = sts.is_scan;
      end
      ST_RD_REV: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_rev   = 1'b1;
        cmd.cap_flow = 1'b1;
      end
      ST_CAP_REV: cmd.cap_rev = 1'b1;
      ST_CALC_A:  cmd.calc_a  = 1'b1;
      ST_CALC_B:  cmd.calc_b  = 1'b1;
      ST_CALC_C:  cmd.calc_c  = 1'b1;
      ST_COMMIT:  cmd.commit  = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/fcea_datapath.sv
// ----------------------------------------------------------------------------
// fcea_datapath
// Flow table memory, counter extension, idle test and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcea_datapath
  import fcea_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctrl_cmd_t             cmd,
  output ctrl_sts_t                  sts,
  input  wire logic                  cfg_write_en,
  input  wire logic [INTERVAL_W-1:0] cfg_write_data,
  input  wire logic                  action,
  input  wire logic [INDEX_W-1:0]    flow_index,
  input  wire logic                  has_reverse,
  input  wire logic [INDEX_W-1:0]    reverse_index,
  input  wire logic                  kernel_present,
  input  wire logic [KBYTES_W-1:0]   kernel_bytes,
  input  wire logic [KPKTS_W-1:0]    kernel_packets,
  input  wire logic                  reverse_kernel_present,
  input  wire logic [KBYTES_W-1:0]   reverse_kernel_bytes,
  input  wire logic [TIME_W-1:0]     current_time,
  input  wire logic                  short_flow,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       aged_out,
  output logic                       short_removed,
  output logic                       export_request,
  output logic [DBYTES_W-1:0]        added_bytes,
  output logic [DPKTS_W-1:0]         added_packets,
  output logic [TOTAL_W-1:0]         total_bytes,
  output logic [TOTAL_W-1:0]         total_packets
);

  logic [INTERVAL_W-1:0] age_interval_us;

  // latched transaction
  logic                act;
  logic [ADDR_W-1:0]   flow_addr;
  logic                has_rev;
  logic [ADDR_W-1:0]   rev_addr;
  logic                kp;
  logic [KBYTES_W-1:0] kb;
  logic [KPKTS_W-1:0]  kpk;
  logic                rkp;
  logic [KBYTES_W-1:0] rkb;
  logic [TIME_W-1:0]   now;
  logic                short_fl;

  entry_t table_mem [FLOW_ENTRIES];
  entry_t rd_data;
  entry_t flow_ent;
  logic [KBYTES_W-1:0] rev_low;
  logic [TIME_W-1:0]   rev_stamp;

  // stage A
  logic [TIME_W-1:0] flow_elapsed;
  logic [TIME_W-1:0] rev_elapsed;
  logic              flow_busy;
  logic              rev_busy;
  logic              bytes_changed;
  logic              bytes_wrap;
  logic              packets_wrap;
  // stage B
  logic               aged;
  logic [TOTAL_W-1:0] new_bytes;
  logic [TOTAL_W-1:0] new_packets;
  // stage C
  logic [DBYTES_W-1:0] delta_bytes;
  logic [DPKTS_W-1:0]  delta_packets;

  logic   flow_idle;
  logic   rev_idle;
  logic   wr_en;
  entry_t wr_entry;
  logic   upd;
  logic   first_exp;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_interval_us <= AGE_INTERVAL_RESET;
    end else if (cfg_write_en) begin
      age_interval_us <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act       <= action;
      flow_addr <= ADDR_W'(flow_index);
      has_rev   <= has_reverse;
      rev_addr  <= ADDR_W'(reverse_index);
      kp        <= kernel_present;
      kb        <= kernel_bytes;
      kpk       <= kernel_packets;
      rkp       <= reverse_kernel_present;
      rkb       <= reverse_kernel_bytes;
      now       <= current_time;
      short_fl  <= short_flow;
    end
  end

  assign sts.is_scan  = (act == ACT_SCAN);
  assign sts.out_free = !out_valid || out_ready;

  // Table with separate read and write ports: one read and one write per cycle.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= table_mem[cmd.rd_rev ? rev_addr : flow_addr];
    end
    if (wr_en) begin
      table_mem[flow_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_flow) flow_ent <= rd_data;
    if (cmd.cap_rev) begin
      rev_low   <= rd_data.byte_total[KBYTES_W-1:0];
      rev_stamp <= rd_data.stamp;
    end
    if (cmd.calc_a) begin
      flow_elapsed  <= now - flow_ent.stamp;
      rev_elapsed   <= now - rev_stamp;
      flow_busy     <= kp && (flow_ent.byte_total[KBYTES_W-1:0] < kb);
      rev_busy      <= rkp && (rev_low < rkb);
      bytes_changed <= flow_ent.byte_total[KBYTES_W-1:0] != kb;
      bytes_wrap    <= flow_ent.byte_total[KBYTES_W-1:0] > kb;
      packets_wrap  <= flow_ent.packet_total[KPKTS_W-1:0] > kpk;
    end
    if (cmd.calc_b) begin
      aged        <= flow_idle && (!has_rev || rev_idle);
      new_bytes   <= {flow_ent.byte_total[TOTAL_W-1:KBYTES_W]
                      + (TOTAL_W-KBYTES_W)'(bytes_wrap), kb};
      new_packets <= {flow_ent.packet_total[TOTAL_W-1:KPKTS_W]
                      + (TOTAL_W-KPKTS_W)'(packets_wrap), kpk};
    end
    if (cmd.calc_c) begin
      // low bits of the difference suffice: the result is reported modulo width
      delta_bytes   <= new_bytes[DBYTES_W-1:0] - flow_ent.byte_total[DBYTES_W-1:0];
      delta_packets <= new_packets[DPKTS_W-1:0] - flow_ent.packet_total[DPKTS_W-1:0];
    end
  end

  assign flow_idle = !flow_busy && ((|flow_elapsed[TIME_W-1:INTERVAL_W])
                     || (flow_elapsed[INTERVAL_W-1:0] >= age_interval_us));
  assign rev_idle  = !rev_busy && ((|rev_elapsed[TIME_W-1:INTERVAL_W])
                     || (rev_elapsed[INTERVAL_W-1:0] >= age_interval_us));

  assign upd       = !aged && kp && bytes_changed;
  assign first_exp = !aged && kp && !bytes_changed && !flow_ent.mark;

  always_comb begin
    wr_en    = 1'b0;
    wr_entry = flow_ent;
    if (cmd.commit) begin
      if (act == ACT_CREATE) begin
        wr_en                 = 1'b1;
        wr_entry.byte_total   = '0;
        wr_entry.packet_total = '0;
        wr_entry.stamp        = now;
        wr_entry.mark         = 1'b0;
      end else if (upd) begin
        wr_en                 = 1'b1;
        wr_entry.byte_total   = new_bytes;
        wr_entry.packet_total = new_packets;
        wr_entry.stamp        = now;
        wr_entry.mark         = 1'b1;
      end else if (first_exp) begin
        wr_en         = 1'b1;
        wr_entry.mark = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (act == ACT_CREATE) begin
        aged_out       <= 1'b0;
        short_removed  <= 1'b0;
        export_request <= 1'b0;
        added_bytes    <= '0;
        added_packets  <= '0;
        total_bytes    <= '0;
        total_packets  <= '0;
      end else begin
        aged_out       <= aged;
        short_removed  <= !aged && short_fl;
        export_request <= upd || first_exp;
        added_bytes    <= upd ? delta_bytes : '0;
        added_packets  <= upd ? delta_packets : '0;
        total_bytes    <= upd ? new_bytes : flow_ent.byte_total;
        total_packets  <= upd ? new_packets : flow_ent.packet_total;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/flow_counter_extend_and_age.sv
// ----------------------------------------------------------------------------
// flow_counter_extend_and_age
// Per-flow statistics table with counter wraparound extension and idle aging.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item: a
//   create item clears a table entry, a scan item brings the kernel counters
//   of a flow and its reverse flow. Output channel (out_valid/out_ready)
//   returns exactly one result per item, in order.
//   Configuration: pulse cfg_write_en with the idle interval in microseconds
//   on cfg_write_data while the block is idle; it takes effect at once.
//   Sequence: a scan item reads the flow entry and then the reverse entry
//   through the single read port of the table memory, and the idle test,
//   extension and delta math run as three registered steps before the commit;
//   a create item reads nothing and goes on to its commit. The next item is
//   taken the cycle after a result is committed, so the block takes no new
//   item while one is in progress.
//   Stall: the result sits in an output register; the block accepts and works
//   on the next item while it waits, and holds in its commit step only while
//   the output register is still full.
//   Reset: rst (synchronous) returns the sequencer to idle, drops any pending
//   result and restores the interval to 180000000 us. Table contents are not
//   cleared; every entry must be created before it is scanned.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_counter_extend_and_age
  import fcea_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [INTERVAL_W-1:0] cfg_write_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  action,
  input  wire logic [INDEX_W-1:0]    flow_index,
  input  wire logic                  has_reverse,
  input  wire logic [INDEX_W-1:0]    reverse_index,
  input  wire logic                  kernel_present,
  input  wire logic [KBYTES_W-1:0]   kernel_bytes,
  input  wire logic [KPKTS_W-1:0]    kernel_packets,
  input  wire logic                  reverse_kernel_present,
  input  wire logic [KBYTES_W-1:0]   reverse_kernel_bytes,
  input  wire logic [TIME_W-1:0]     current_time,
  input  wire logic                  short_flow,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       aged_out,
  output logic                       short_removed,
  output logic                       export_request,
  output logic [DBYTES_W-1:0]        added_bytes,
  output logic [DPKTS_W-1:0]         added_packets,
  output logic [TOTAL_W-1:0]         total_bytes,
  output logic [TOTAL_W-1:0]         total_packets
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence the table reads, compute steps and commit.
  fcea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the table, the interval register and the result register.
  fcea_datapath u_datapath (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_write_en           (cfg_write_en),
    .cfg_write_data         (cfg_write_data),
    .action                 (action),
    .flow_index             (flow_index),
    .has_reverse            (has_reverse),
    .reverse_index          (reverse_index),
    .kernel_present         (kernel_present),
    .kernel_bytes           (kernel_bytes),
    .kernel_packets         (kernel_packets),
    .reverse_kernel_present (reverse_kernel_present),
    .reverse_kernel_bytes   (reverse_kernel_bytes),
    .current_time           (current_time),
    .short_flow             (short_flow),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .aged_out               (aged_out),
    .short_removed          (short_removed),
    .export_request         (export_request),
    .added_bytes            (added_bytes),
    .added_packets          (added_packets),
    .total_bytes            (total_bytes),
    .total_packets          (total_packets)
  );

endmodule

`default_nettype wire

// File: tb/flow_stats_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_stats_pkg
// Transaction types and the statistics-table scoreboard for the flow counter
// testbench: a shadow copy of the table that predicts each result.
// ----------------------------------------------------------------------------

package flow_stats_pkg;

  import fcea_pkg::*;

  // One input transaction, field for field as on the ports.
  typedef struct packed {
    logic                action;
    logic [INDEX_W-1:0]  flow_index;
    logic                has_reverse;
    logic [INDEX_W-1:0]  reverse_index;
    logic                kernel_present;
    logic [KBYTES_W-1:0] kernel_bytes;
    logic [KPKTS_W-1:0]  kernel_packets;
    logic                reverse_kernel_present;
    logic [KBYTES_W-1:0] reverse_kernel_bytes;
    logic [TIME_W-1:0]   current_time;
    logic                short_flow;
  } flow_item_t;

  // One result transaction.
  typedef struct packed {
    logic                aged_out;
    logic                short_removed;
    logic                export_request;
    logic [DBYTES_W-1:0] added_bytes;
    logic [DPKTS_W-1:0]  added_packets;
    logic [TOTAL_W-1:0]  total_bytes;
    logic [TOTAL_W-1:0]  total_packets;
  } flow_stats_t;

  class flow_stats_board;
    logic [TOTAL_W-1:0]    byte_tot [FLOW_ENTRIES];
    logic [TOTAL_W-1:0]    pkt_tot [FLOW_ENTRIES];
    logic [TIME_W-1:0]     touched [FLOW_ENTRIES];
    bit                    exported [FLOW_ENTRIES];
    logic [INTERVAL_W-1:0] age_interval;
    flow_stats_t           expected_stats [$];
    int                    errors;

    function new();
      age_interval = AGE_INTERVAL_RESET;
      errors = 0;
      foreach (byte_tot[i]) begin
        byte_tot[i] = '0;
        pkt_tot[i]  = '0;
        touched[i]  = '0;
        exported[i] = 1'b0;
      end
    endfunction

    function void set_interval(logic [INTERVAL_W-1:0] value);
      age_interval = value;
    endfunction

    // Idle: kernel bytes did not move past the stored low part, and the
    // entry has not changed for at least the interval (time wraps).
    function bit entry_idle(int unsigned idx, logic present, logic [KBYTES_W-1:0] kb,
                            logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      elapsed = now - touched[idx];
      if (present && byte_tot[idx][KBYTES_W-1:0] < kb)
        return 1'b0;
      return elapsed >= TIME_W'(age_interval);
    endfunction

    // Work out one result and advance the shadow table.
    function flow_stats_t age_and_extend(flow_item_t it);
      flow_stats_t                 r;
      int unsigned                 fi;
      int unsigned                 ri;
      bit                          idle;
      logic [TOTAL_W-KBYTES_W-1:0] byte_hi;
      logic [TOTAL_W-KPKTS_W-1:0]  pkt_hi;
      logic [TOTAL_W-1:0]          new_bytes;
      logic [TOTAL_W-1:0]          new_pkts;
      r  = '0;
      fi = int'(it.flow_index) % FLOW_ENTRIES;
      ri = int'(it.reverse_index) % FLOW_ENTRIES;
      if (it.action == ACT_CREATE) begin
        byte_tot[fi] = '0;
        pkt_tot[fi]  = '0;
        touched[fi]  = it.current_time;
        exported[fi] = 1'b0;
        return r;
      end
      // The reverse test reads the table before any update of this step.
      idle = entry_idle(fi, it.kernel_present, it.kernel_bytes, it.current_time);
      if (idle && it.has_reverse)
        idle = entry_idle(ri, it.reverse_kernel_present, it.reverse_kernel_bytes,
                          it.current_time);
      if (idle) begin
        r.aged_out = 1'b1;
      end else begin
        if (it.kernel_present) begin
          if (byte_tot[fi][KBYTES_W-1:0] != it.kernel_bytes) begin
            // Kernel counter below the stored low part: carry into the upper bits.
            byte_hi = byte_tot[fi][TOTAL_W-1:KBYTES_W];
            if (byte_tot[fi][KBYTES_W-1:0] > it.kernel_bytes)
              byte_hi = byte_hi + 1'b1;
            pkt_hi = pkt_tot[fi][TOTAL_W-1:KPKTS_W];
            if (pkt_tot[fi][KPKTS_W-1:0] > it.kernel_packets)
              pkt_hi = pkt_hi + 1'b1;
            new_bytes = {byte_hi, it.kernel_bytes};
            new_pkts  = {pkt_hi, it.kernel_packets};
            r.added_bytes   = DBYTES_W'(new_bytes - byte_tot[fi]);
            r.added_packets = DPKTS_W'(new_pkts - pkt_tot[fi]);
            byte_tot[fi] = new_bytes;
            pkt_tot[fi]  = new_pkts;
            touched[fi]  = it.current_time;
            exported[fi] = 1'b1;
            r.export_request = 1'b1;
          end else if (!exported[fi]) begin
            exported[fi] = 1'b1;
            r.export_request = 1'b1;
          end
        end
        r.short_removed = it.short_flow;
      end
      r.total_bytes   = byte_tot[fi];
      r.total_packets = pkt_tot[fi];
      return r;
    endfunction

    function void note_item(flow_item_t it);
      expected_stats.push_back(age_and_extend(it));
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(flow_stats_t got);
      flow_stats_t want;
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t: result expected none, actual %h", $time, got);
        return;
      end
      want = expected_stats.pop_front();
      compare_field("aged_out", 64'(want.aged_out), 64'(got.aged_out));
      compare_field("short_removed", 64'(want.short_removed), 64'(got.short_removed));
      compare_field("export_request", 64'(want.export_request), 64'(got.export_request));
      compare_field("added_bytes", 64'(want.added_bytes), 64'(got.added_bytes));
      compare_field("added_packets", 64'(want.added_packets), 64'(got.added_packets));
      compare_field("total_bytes", want.total_bytes, got.total_bytes);
      compare_field("total_packets", want.total_packets, got.total_packets);
    endfunction
  endclass

endpackage

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives create and scan transactions into the flow statistics table and
// checks every result against a shadow table. A directed opening covers
// creates, counter wraparound, first export, absent kernel counters, short
// flows and aging with and without a reverse flow; random phases follow, one
// per idle interval, with random gaps on both channels.
// ----------------------------------------------------------------------------

module testbench;

  import fcea_pkg::*;
  import flow_stats_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 75;
  localparam int PHASES       = 6;
  localparam int SETTLE_TICKS = 16;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic [INTERVAL_W-1:0] cfg_write_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  action = ACT_CREATE;
  logic [INDEX_W-1:0]    flow_index = '0;
  logic                  has_reverse = 1'b0;
  logic [INDEX_W-1:0]    reverse_index = '0;
  logic                  kernel_present = 1'b0;
  logic [KBYTES_W-1:0]   kernel_bytes = '0;
  logic [KPKTS_W-1:0]    kernel_packets = '0;
  logic                  reverse_kernel_present = 1'b0;
  logic [KBYTES_W-1:0]   reverse_kernel_bytes = '0;
  logic [TIME_W-1:0]     current_time = '0;
  logic                  short_flow = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  aged_out;
  logic                  short_removed;
  logic                  export_request;
  logic [DBYTES_W-1:0]   added_bytes;
  logic [DPKTS_W-1:0]    added_packets;
  logic [TOTAL_W-1:0]    total_bytes;
  logic [TOTAL_W-1:0]    total_packets;

  flow_stats_board       board;
  int unsigned           live_flows [$];   // entries that have been created
  logic [TIME_W-1:0]     clock_us;         // running time of the stimulus
  bit                    steady_send;
  bit                    steady_recv;
  int                    stall_left;
  int                    cycle_count;

  flow_counter_extend_and_age dut (
    .clk                    (clk),
    .rst                    (rst),
    .cfg_write_en           (cfg_write_en),
    .cfg_write_data         (cfg_write_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .action                 (action),
    .flow_index             (flow_index),
    .has_reverse            (has_reverse),
    .reverse_index          (reverse_index),
    .kernel_present         (kernel_present),
    .kernel_bytes           (kernel_bytes),
    .kernel_packets         (kernel_packets),
    .reverse_kernel_present (reverse_kernel_present),
    .reverse_kernel_bytes   (reverse_kernel_bytes),
    .current_time           (current_time),
    .short_flow             (short_flow),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .aged_out               (aged_out),
    .short_removed          (short_removed),
    .export_request         (export_request),
    .added_bytes            (added_bytes),
    .added_packets          (added_packets),
    .total_bytes            (total_bytes),
    .total_packets          (total_packets)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then roll the next ready.
  // Stalls are mostly short with a few long ones; now and then switch to a
  // stretch where ready stays high.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result({aged_out, short_removed, export_request, added_bytes,
                          added_packets, total_bytes, total_packets});
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(149) == 0)
        steady_recv = !steady_recv;
      if (!steady_recv) begin
        case ($urandom_range(99)) inside
          [0:19]:  stall_left = $urandom_range(1, 3);
          [20:24]: stall_left = $urandom_range(5, 40);
          default: stall_left = 0;
        endcase
      end
    end
  end

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(99);
    if (steady_send || pick < 60)
      return 0;
    if (pick < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Present one transaction, hold it until accepted, then idle for a while.
  task automatic send_item(input flow_item_t it);
    int gap;
    in_valid               <= 1'b1;
    action                 <= it.action;
    flow_index             <= it.flow_index;
    has_reverse            <= it.has_reverse;
    reverse_index          <= it.reverse_index;
    kernel_present         <= it.kernel_present;
    kernel_bytes           <= it.kernel_bytes;
    kernel_packets         <= it.kernel_packets;
    reverse_kernel_present <= it.reverse_kernel_present;
    reverse_kernel_bytes   <= it.reverse_kernel_bytes;
    current_time           <= it.current_time;
    short_flow             <= it.short_flow;
    do @(posedge clk); while (!in_ready);
    board.note_item(it);
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    board.set_interval(value);
  endtask

  // Create transaction; kernel fields and the short mark carry junk that the
  // block must ignore.
  function automatic flow_item_t create_item(int unsigned fi, logic [TIME_W-1:0] t);
    flow_item_t it;
    it = '1;
    it.action        = ACT_CREATE;
    it.flow_index    = INDEX_W'(fi);
    it.reverse_index = INDEX_W'(~fi);
    it.current_time  = t;
    return it;
  endfunction

  function automatic flow_item_t scan_item(int unsigned fi, logic rev, int unsigned ri,
                                           logic kp, logic [KBYTES_W-1:0] kb,
                                           logic [KPKTS_W-1:0] kpk, logic rkp,
                                           logic [KBYTES_W-1:0] rkb,
                                           logic [TIME_W-1:0] t, logic shrt);
    flow_item_t it;
    it.action                 = ACT_SCAN;
    it.flow_index             = INDEX_W'(fi);
    it.has_reverse            = rev;
    it.reverse_index          = INDEX_W'(ri);
    it.kernel_present         = kp;
    it.kernel_bytes           = kb;
    it.kernel_packets         = kpk;
    it.reverse_kernel_present = rkp;
    it.reverse_kernel_bytes   = rkb;
    it.current_time           = t;
    it.short_flow             = shrt;
    return it;
  endfunction

  // Random transaction. Scans only touch created entries, and kernel
  // counters are drawn near the stored totals so that unchanged counters,
  // small advances and wraparounds all come up often.
  function automatic flow_item_t next_random_item();
    flow_item_t          it;
    int unsigned         fi;
    int unsigned         ri;
    int                  pick;
    logic [KBYTES_W-1:0] low_bytes;
    logic [KPKTS_W-1:0]  low_pkts;
    logic [KBYTES_W-1:0] rev_low;
    it.has_reverse            = 1'($urandom);
    it.reverse_index          = INDEX_W'($urandom);
    it.kernel_present         = 1'($urandom);
    it.kernel_bytes           = KBYTES_W'({$urandom, $urandom});
    it.kernel_packets         = KPKTS_W'({$urandom, $urandom});
    it.reverse_kernel_present = 1'($urandom);
    it.reverse_kernel_bytes   = KBYTES_W'({$urandom, $urandom});
    it.short_flow             = 1'($urandom);

    if ($urandom_range(99) < 12) begin
      if (live_flows.size() < 40 && $urandom_range(1) == 1) begin
        fi = $urandom_range(FLOW_ENTRIES - 1);
        live_flows.push_back(fi);
      end else begin
        fi = live_flows[$urandom_range(live_flows.size() - 1)];
      end
      clock_us += TIME_W'($urandom_range(0, 2000));
      it.action       = ACT_CREATE;
      it.flow_index   = INDEX_W'(fi);
      it.current_time = clock_us;
      return it;
    end

    fi = live_flows[$urandom_range(live_flows.size() - 1)];
    ri = ($urandom_range(9) == 0) ? fi : live_flows[$urandom_range(live_flows.size() - 1)];
    it.action         = ACT_SCAN;
    it.flow_index     = INDEX_W'(fi);
    it.reverse_index  = INDEX_W'(ri);
    it.kernel_present = $urandom_range(99) < 85;
    it.reverse_kernel_present = $urandom_range(99) < 75;
    it.short_flow     = $urandom_range(99) < 15;

    low_bytes = board.byte_tot[fi][KBYTES_W-1:0];
    pick = $urandom_range(99);
    if (pick < 30)
      it.kernel_bytes = low_bytes;
    else if (pick < 60)
      it.kernel_bytes = low_bytes + KBYTES_W'($urandom_range(1, 5000));
    else if (pick < 85)
      it.kernel_bytes = low_bytes + KBYTES_W'({$urandom, $urandom});

    low_pkts = board.pkt_tot[fi][KPKTS_W-1:0];
    if ($urandom_range(1) == 0)
      it.kernel_packets = low_pkts + KPKTS_W'($urandom_range(0, 100));

    rev_low = board.byte_tot[ri][KBYTES_W-1:0];
    pick = $urandom_range(99);
    if (pick < 40)
      it.reverse_kernel_bytes = rev_low;
    else if (pick < 60)
      it.reverse_kernel_bytes = rev_low - KBYTES_W'($urandom_range(1, 50));
    else if (pick < 80)
      it.reverse_kernel_bytes = rev_low + KBYTES_W'($urandom_range(1, 50));

    // Advance time: small steps, landing right at the aging boundary of
    // this flow, wide jumps, or an arbitrary point (time may run backward).
    pick = $urandom_range(99);
    if (pick < 45)
      clock_us += TIME_W'($urandom_range(0, 2000));
    else if (pick < 70)
      clock_us = board.touched[fi] + TIME_W'(board.age_interval)
                 + TIME_W'($urandom_range(0, 4)) - TIME_W'(2);
    else if (pick < 90)
      clock_us += {$urandom, $urandom} >> $urandom_range(0, 63);
    else
      clock_us = {$urandom, $urandom};
    it.current_time = clock_us;
    return it;
  endfunction

  initial begin
    logic [INTERVAL_W-1:0] phase_interval [PHASES];
    logic [TIME_W-1:0]     iv;

    board      = new();
    clock_us   = TIME_W'(1000);
    iv         = TIME_W'(AGE_INTERVAL_RESET);
    stall_left = 0;

    phase_interval[0] = INTERVAL_W'(1000);
    phase_interval[1] = '0;
    phase_interval[2] = '1;
    phase_interval[3] = {8'($urandom), 32'($urandom)};
    phase_interval[4] = AGE_INTERVAL_RESET;
    phase_interval[5] = INTERVAL_W'(5000);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, under the reset interval.
    send_item(create_item('h000, 1000));
    send_item(create_item('hFFF, 1000));
    send_item(create_item('hAAA, 1000));
    send_item(create_item('h555, 1000));
    // counters advance, then stay, then wrap below the stored low parts
    send_item(scan_item('h000, 0, 'hFFF, 1, 100, 5, 0, 0, 2000, 0));
    send_item(scan_item('h000, 0, 'hFFF, 1, 100, 9, 0, 0, 2100, 0));
    send_item(scan_item('h000, 0, 'hFFF, 1, 40, 3, 0, 0, 2200, 0));
    // first export with unchanged bytes
    send_item(scan_item('h555, 0, 'h000, 1, 0, 0, 0, 0, 2300, 0));
    // kernel absent and short flow; then aging exactly at the interval
    send_item(scan_item('hFFF, 0, 'h000, 0, 7, 7, 0, 0, 2400, 1));
    send_item(scan_item('hFFF, 0, 'h000, 0, 0, 0, 0, 0, 1000 + iv, 0));
    // one microsecond short of the interval: short flow is removed
    send_item(scan_item('hAAA, 0, 'h555, 0, 0, 0, 0, 0, 1000 + iv - 1, 1));
    // idle flow, busy reverse flow; then both idle
    send_item(scan_item('hAAA, 1, 'h555, 0, 0, 0, 1, 5, 1000 + 2 * iv, 0));
    send_item(scan_item('hAAA, 1, 'h555, 0, 0, 0, 1, 0, 2300 + 2 * iv, 0));
    // flow paired with itself: idle, then held by its own reverse test
    send_item(scan_item('h555, 1, 'h555, 1, 0, 0, 1, 0, 1000 + 3 * iv, 0));
    send_item(scan_item('h555, 1, 'h555, 1, 0, 0, 1, 7, 1000 + 3 * iv, 1));
    // largest kernel counters, then wrap to zero
    send_item(scan_item('h000, 0, 'h555, 1, '1, '1, 1, '1, 2300, 0));
    send_item(scan_item('h000, 0, 'h555, 1, 0, 0, 1, '1, 2400, 0));
    // time wraps around the top of the 64-bit range
    send_item(create_item('h123, '1));
    send_item(scan_item('h123, 0, 'h000, 1, 1, 1, 0, 0, 5, 0));
    send_item(scan_item('h123, 0, 'h000, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0000, 0));
    live_flows = '{'h000, 'hFFF, 'hAAA, 'h555, 'h123};

    // Random phases, one per interval setting; drain before each write.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_interval(phase_interval[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 25 == 0)
          steady_send = ($urandom_range(3) == 0);
        send_item(next_random_item());
      end
    end

    // Let the last results arrive, then watch for strays.
    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (board.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
rtl/core/fcea_pkg.sv
rtl/core/fcea_ctrl.sv
rtl/core/fcea_datapath.sv
rtl/core/flow_counter_extend_and_age.sv
tb/flow_stats_pkg.sv
tb/testbench.sv
